@@ hw/rtl/combination_unrank_unit_macros.svh @@
// assertion macros shared by the combination unrank checker
`ifndef COMBINATION_UNRANK_UNIT_MACROS_SVH
`define COMBINATION_UNRANK_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cu_pkg.sv @@
// shared types, constants and binomial table function for the combination unrank unit
package cu_pkg;

	// fixed field widths
	localparam int K_W      = 5;
	localparam int RANK_W   = 14;
	localparam int NSET_W   = 5;
	localparam int ELEM_W   = 4;
	localparam int POS_W    = 4;

	// default and limits
	localparam int MAX_SET_DEF  = 16;
	localparam int MAX_RESULTS  = 16;
	localparam int SET_SIZE_RST = 16;

	// binomials saturate just above the largest rank
	localparam int BINOM_W   = RANK_W + 1;
	localparam int BINOM_SAT = 2 ** RANK_W;
	localparam int TAB_MAX   = 32;

	// job handed from front to back
	typedef struct packed {
		logic [K_W-1:0]     k;
		logic [RANK_W-1:0]  rank;
		logic [NSET_W-1:0]  n;
		logic [BINOM_W-1:0] first_cnt;
		logic               err;
	} cu_job_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		BE_IDLE,
		BE_WALK,
		BE_FAULT
	} be_state_t;

	// saturated C(a, b) by pascal rows, elaboration-time only
	function automatic logic [BINOM_W-1:0] binom(input int a, input int b);
		logic [BINOM_W-1:0] row [0:TAB_MAX-1];
		logic [BINOM_W:0]   sum;
		int                 i;
		int                 j;
		for (i = 0; i < TAB_MAX; i++) begin
			row[i] = '0;
		end
		row[0] = BINOM_W'(1);
		for (i = 1; i <= a; i++) begin
			for (j = i; j >= 1; j--) begin
				sum = {1'b0, row[j]} + {1'b0, row[j-1]};
				row[j] = (sum > (BINOM_W+1)'(BINOM_SAT)) ? BINOM_W'(BINOM_SAT)
					: sum[BINOM_W-1:0];
			end
		end
		if (b < 0 || b > a || a >= TAB_MAX) begin
			return '0;
		end
		return row[b];
	endfunction

endpackage

@@ hw/rtl/cu_front.sv @@
// front end: set size register, input stage and request classification
module cu_front #(
	parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cu_pkg::NSET_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [cu_pkg::K_W-1:0]    in_k,
	input  logic [cu_pkg::RANK_W-1:0] in_rank,
	output logic                      job_valid,
	input  logic                      job_ready,
	output cu_pkg::cu_job_t           job
);
	import cu_pkg::*;

	localparam int IDX_W = $clog2(MAX_SET + 1);
	localparam int DIM   = 2 ** IDX_W;

	logic [NSET_W-1:0]  set_size_q;
	logic               s1_vld;
	logic [K_W-1:0]     k_s1;
	logic [RANK_W-1:0]  rank_s1;
	logic [NSET_W-1:0]  n_s1;
	logic [NSET_W-1:0]  n_clamp;
	logic               s1_go;
	logic               k_big;
	logic [IDX_W-1:0]   n_idx;
	logic [IDX_W-1:0]   k_idx;
	logic [BINOM_W-1:0] total;
	logic [BINOM_W-1:0] tab [DIM][DIM];

	// constant binomial table
	for (genvar ga = 0; ga < DIM; ga++) begin : g_row
		for (genvar gb = 0; gb < DIM; gb++) begin : g_col
			assign tab[ga][gb] = binom(ga, gb);
		end
	end

	// set size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= NSET_W'(SET_SIZE_RST);
		end else if (cfg_we) begin
			set_size_q <= cfg_wdata;
		end
	end

	assign n_clamp = (set_size_q > NSET_W'(MAX_SET)) ? NSET_W'(MAX_SET) : set_size_q;

	// empty subsets are dropped here, others go to the queue
	assign s1_go    = (k_s1 == '0) || job_ready;
	assign in_ready = !s1_vld || s1_go;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (in_ready) begin
			s1_vld <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			k_s1    <= in_k;
			rank_s1 <= in_rank;
			n_s1    <= n_clamp;
		end
	end

	// classify: range checks and first count of the walk
	assign k_big = (k_s1 > n_s1) || (k_s1 > K_W'(MAX_RESULTS));
	assign n_idx = n_s1[IDX_W-1:0];
	assign k_idx = k_big ? '0 : k_s1[IDX_W-1:0];
	assign total = tab[n_idx][k_idx];

	assign job_valid     = s1_vld && (k_s1 != '0);
	assign job.k         = k_s1;
	assign job.rank      = rank_s1;
	assign job.n         = n_s1;
	assign job.err       = k_big || ({1'b0, rank_s1} >= total);
	assign job.first_cnt = tab[IDX_W'(n_idx - 1'b1)][IDX_W'(k_idx - 1'b1)];

endmodule

@@ hw/rtl/cu_queue.sv @@
// two-entry job queue between front and back
module cu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cu_pkg::cu_job_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cu_pkg::cu_job_t pop_data
);
	import cu_pkg::*;

	cu_job_t     mem [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/cu_back.sv @@
// back end: candidate walk sequencer and result register
module cu_back #(
	parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  cu_pkg::cu_job_t           job,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [cu_pkg::ELEM_W-1:0] res_elem,
	output logic [cu_pkg::POS_W-1:0]  res_pos,
	output logic                      res_last,
	output logic                      res_err
);
	import cu_pkg::*;

	localparam int IDX_W = $clog2(MAX_SET + 1);
	localparam int DIM   = 2 ** IDX_W;

	be_state_t          state_q;
	be_state_t          state_d;
	logic [RANK_W-1:0]  x_q;
	logic [IDX_W-1:0]   a_q;
	logic [IDX_W-1:0]   c_q;
	logic [POS_W-1:0]   r_q;
	logic [POS_W-1:0]   pos_q;
	logic [BINOM_W-1:0] cs_q;
	logic               res_vld_q;
	logic [ELEM_W-1:0]  res_elem_q;
	logic [POS_W-1:0]   res_pos_q;
	logic               res_last_q;
	logic               res_err_q;
	logic               out_free;
	logic               x_ge;
	logic               pop;
	logic               skip;
	logic               take;
	logic               emit_err;
	logic [IDX_W-1:0]   a_dn;
	logic [IDX_W-1:0]   r_idx;
	logic [BINOM_W-1:0] skip_cnt;
	logic [BINOM_W-1:0] take_cnt;
	logic [BINOM_W-1:0] tab [DIM][DIM];

	// constant binomial table
	for (genvar ga = 0; ga < DIM; ga++) begin : g_row
		for (genvar gb = 0; gb < DIM; gb++) begin : g_col
			assign tab[ga][gb] = binom(ga, gb);
		end
	end

	// both next counts read in parallel with the compare
	assign a_dn     = IDX_W'(a_q - 1'b1);
	assign r_idx    = IDX_W'(r_q);
	assign skip_cnt = tab[a_dn][r_idx];
	assign take_cnt = tab[a_dn][IDX_W'(r_idx - 1'b1)];
	assign x_ge     = ({1'b0, x_q} >= cs_q);
	assign out_free = !res_vld_q || res_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and step controls
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		skip     = 1'b0;
		take     = 1'b0;
		emit_err = 1'b0;
		unique case (state_q)
			BE_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					state_d = job.err ? BE_FAULT : BE_WALK;
				end
			end
			BE_WALK: begin
				if (x_ge) begin
					skip = 1'b1;
				end else if (out_free) begin
					take = 1'b1;
					if (r_q == '0) begin
						state_d = BE_IDLE;
					end
				end
			end
			BE_FAULT: begin
				if (out_free) begin
					emit_err = 1'b1;
					state_d  = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	assign job_ready = pop;

	// walk registers: x is the remaining rank, cs the count C(a, r)
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q   <= job.rank;
			a_q   <= IDX_W'(job.n[IDX_W-1:0] - 1'b1);
			c_q   <= '0;
			r_q   <= POS_W'(job.k - 1'b1);
			pos_q <= '0;
			cs_q  <= job.first_cnt;
		end else if (skip) begin
			x_q  <= x_q - cs_q[RANK_W-1:0];
			a_q  <= a_dn;
			c_q  <= c_q + 1'b1;
			cs_q <= skip_cnt;
		end else if (take) begin
			a_q   <= a_dn;
			c_q   <= c_q + 1'b1;
			r_q   <= r_q - 1'b1;
			pos_q <= pos_q + 1'b1;
			cs_q  <= take_cnt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (take || emit_err) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			res_elem_q <= ELEM_W'(c_q);
			res_pos_q  <= pos_q;
			res_last_q <= (r_q == '0);
			res_err_q  <= 1'b0;
		end else if (emit_err) begin
			res_elem_q <= '0;
			res_pos_q  <= '0;
			res_last_q <= 1'b1;
			res_err_q  <= 1'b1;
		end
	end

	assign res_valid = res_vld_q;
	assign res_elem  = res_elem_q;
	assign res_pos   = res_pos_q;
	assign res_last  = res_last_q;
	assign res_err   = res_err_q;

endmodule

@@ hw/rtl/combination_unrank_unit.sv @@
// From input accept a request passes the input stage register and the job queue before the
// back end loads it; it holds each job until the largest element or error item is emitted.
// The sequencer walks one table step per clock, but a take waits for a free result register.
// An empty subset is dropped in the front stage and never reaches the queue.
// Reset: set_size returns to 16, stages, queue and result register are emptied.
module combination_unrank_unit #(
	parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cu_pkg::NSET_W-1:0] cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,  // subset_size[4:0], rank[18:5]
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [7:0]                m_axis_tdata,  // element[3:0], position[7:4]
	output logic                      m_axis_tlast,
	output logic                      m_axis_tuser   // error
);
	import cu_pkg::*;

	logic    f_job_valid;
	logic    f_job_ready;
	cu_job_t f_job;
	logic    b_job_valid;
	logic    b_job_ready;
	cu_job_t b_job;

	// request intake and classification
	cu_front #(.MAX_SET(MAX_SET)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_k      (s_axis_tdata[K_W-1:0]),
		.in_rank   (s_axis_tdata[K_W+RANK_W-1:K_W]),
		.job_valid (f_job_valid),
		.job_ready (f_job_ready),
		.job       (f_job)
	);

	// decoupling queue
	cu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_job_valid),
		.push_ready (f_job_ready),
		.push_data  (f_job),
		.pop_valid  (b_job_valid),
		.pop_ready  (b_job_ready),
		.pop_data   (b_job)
	);

	// walk and result output
	cu_back #(.MAX_SET(MAX_SET)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_job_valid),
		.job_ready (b_job_ready),
		.job       (b_job),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_elem  (m_axis_tdata[ELEM_W-1:0]),
		.res_pos   (m_axis_tdata[ELEM_W+POS_W-1:ELEM_W]),
		.res_last  (m_axis_tlast),
		.res_err   (m_axis_tuser)
	);

endmodule

@@ hw/rtl/cu_checker.sv @@
// port-level checks on the result stream of the combination unrank unit
`include "combination_unrank_unit_macros.svh"

module cu_checker #(
	parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);
	import cu_pkg::*;

	logic              prev_done_q;
	logic [ELEM_W-1:0] prev_elem_q;
	logic [POS_W-1:0]  prev_pos_q;
	logic [ELEM_W-1:0] elem;
	logic [POS_W-1:0]  pos;
	logic              out_acc;

	assign elem    = m_axis_tdata[ELEM_W-1:0];
	assign pos     = m_axis_tdata[ELEM_W+POS_W-1:ELEM_W];
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// track the previous accepted item of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_done_q <= 1'b1;
		end else if (out_acc) begin
			prev_done_q <= m_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_elem_q <= elem;
			prev_pos_q  <= pos;
		end
	end

	// a stalled result stays offered
	`CU_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")

	// an error item is a lone, zeroed, final item
	`CU_ASSERT_NOW(a_err_shape, m_axis_tvalid && m_axis_tuser, m_axis_tlast && m_axis_tdata == 8'd0 && prev_done_q, "malformed error item")

	// a run starts at position zero
	`CU_ASSERT_NOW(a_run_start, m_axis_tvalid && prev_done_q, pos == '0, "run does not start at position zero")

	// within a run positions count up and elements rise
	`CU_ASSERT_NOW(a_run_order, m_axis_tvalid && !prev_done_q, pos == POS_W'(prev_pos_q + 1'b1) && !m_axis_tuser && (MAX_SET > 16 || elem > prev_elem_q), "run out of order")

endmodule

bind combination_unrank_unit cu_checker #(.MAX_SET(MAX_SET)) u_cu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
